// ===== rtl/i2c_master_register_transfer_top_assert.svh =====
// Assertion macros used by the sequencer.
`ifndef I2C_MASTER_REGISTER_TRANSFER_TOP_ASSERT_SVH
`define I2C_MASTER_REGISTER_TRANSFER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define I2CM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define I2CM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants of the I2C register transfer master.
// ----------------------------------------------------------------------------
package i2cm_pkg;
  localparam int unsigned MAX_LEN_DEF = 255;
  localparam int unsigned CFG_AW = 4;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_RECOVER = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BUS_BUSY = 3'd1;
  localparam logic [2:0] ST_ADDR_NACK = 3'd2;
  localparam logic [2:0] ST_OFF_NACK = 3'd3;
  localparam logic [2:0] ST_DATA_NACK = 3'd4;
  localparam logic [2:0] ST_STOP_FAIL = 3'd5;

  localparam logic [1:0] REG_HALF = 2'd0;
  localparam logic [1:0] REG_WA = 2'd1;
  localparam logic [1:0] REG_WB = 2'd2;
  localparam logic [1:0] REG_WC = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  dev_addr;
    logic [15:0] reg_offset;
    logic [7:0]  xfer_length;
    logic [7:0]  wr_data;
    logic        wr_data_valid;
    logic        scl_in;
    logic        sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       wr_data_taken;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } out_word_t;

  typedef struct packed {
    logic [15:0] half_period;
    logic [7:0]  wide_a;
    logic [7:0]  wide_b;
    logic [7:0]  wide_c;
  } cfg_t;

  typedef enum logic [12:0] {
    P_IDLE      = 13'b0000000000001,
    P_ST_A      = 13'b0000000000010,
    P_ST_B      = 13'b0000000000100,
    P_ST_C      = 13'b0000000001000,
    P_BIT_LOW   = 13'b0000000010000,
    P_BIT_HIGH  = 13'b0000000100000,
    P_WAIT_DATA = 13'b0000001000000,
    P_SP_A      = 13'b0000010000000,
    P_SP_B      = 13'b0000100000000,
    P_SP_C      = 13'b0001000000000,
    P_SP_D      = 13'b0010000000000,
    P_REC_HI    = 13'b0100000000000,
    P_REC_LO    = 13'b1000000000000
  } phase_t;

  typedef enum logic [5:0] {
    S_ADDR_W = 6'b000001,
    S_OFF_HI = 6'b000010,
    S_OFF_LO = 6'b000100,
    S_DATA_W = 6'b001000,
    S_ADDR_R = 6'b010000,
    S_DATA_R = 6'b100000
  } stage_t;
endpackage

// ===== rtl/i2cm_stream_if.sv =====
// ----------------------------------------------------------------------------
// i2cm_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface i2cm_stream_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/i2cm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// i2cm_cfg_regs
// APB-style register file for timing and wide-offset device addresses.
// ----------------------------------------------------------------------------
module i2cm_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [i2cm_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output i2cm_pkg::cfg_t              cfg
);
  import i2cm_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{half_period: 16'd5, wide_a: 8'd0, wide_b: 8'd0, wide_c: 8'd0};
    end else if (wr_en) begin
      case (idx)
        REG_HALF: cfg_r.half_period <= pwdata[15:0];
        REG_WA:   cfg_r.wide_a <= pwdata[7:0];
        REG_WB:   cfg_r.wide_b <= pwdata[7:0];
        REG_WC:   cfg_r.wide_c <= pwdata[7:0];
        default:  cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HALF: prdata = {16'd0, cfg_r.half_period};
      REG_WA:   prdata = {24'd0, cfg_r.wide_a};
      REG_WB:   prdata = {24'd0, cfg_r.wide_b};
      REG_WC:   prdata = {24'd0, cfg_r.wide_c};
      default:  prdata = 32'd0;
    endcase
  end
endmodule

// ===== rtl/i2cm_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2cm_sequencer
// One tick of the I2C bus sequencer: state update and result word.
// ----------------------------------------------------------------------------
module i2cm_sequencer #(
  parameter int unsigned MAX_LEN = i2cm_pkg::MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  i2cm_pkg::in_word_t  in_w,
  input  i2cm_pkg::cfg_t      cfg,
  output i2cm_pkg::out_word_t res
);
  import i2cm_pkg::*;
  `include "i2c_master_register_transfer_top_assert.svh"

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam logic [7:0] LEN_CAP = (MAX_LEN > 255) ? 8'hFF : 8'(MAX_LEN);

  phase_t      phase_r, phase_nxt;
  stage_t      stage_r, stage_nxt;
  logic [16:0] tick_r, tick_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        wide_r, wide_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [15:0] off_r, off_nxt;
  logic        rd_r, rd_nxt;
  logic [2:0]  code_r, code_nxt;
  logic        scl_r, scl_nxt, sda_r, sda_nxt;
  logic [16:0] tinc;
  logic [16:0] hp;
  logic        tdone;
  logic [7:0]  rdd;
  logic        rdv, taken, done;
  logic [LW:0] nlen;

  assign hp    = (cfg.half_period == 16'd0) ? 17'd1 : {1'b0, cfg.half_period};
  assign tinc  = tick_r + 17'd1;
  assign tdone = (tinc >= hp);

  always_comb begin
    logic [3:0] bi;
    logic [7:0] nb;
    phase_nxt = phase_r; stage_nxt = stage_r; tick_nxt = tick_r; bit_nxt = bit_r;
    shift_nxt = shift_r; left_nxt = left_r; wide_nxt = wide_r; dev_nxt = dev_r;
    off_nxt = off_r; rd_nxt = rd_r; code_nxt = code_r; scl_nxt = scl_r;
    sda_nxt = sda_r; rdd = 8'd0; rdv = 1'b0; taken = 1'b0; done = 1'b0;
    nlen = '0; bi = 4'd0; nb = 8'd0;
    // Timer advances in every timed phase, held while SCL is stretched; it clears on expiry.
    if (phase_r != P_IDLE && phase_r != P_WAIT_DATA &&
        !(phase_r == P_BIT_HIGH && !in_w.scl_in)) begin
      tick_nxt = tdone ? 17'd0 : tinc;
    end
    case (phase_r)
      P_IDLE: begin
        if (in_w.req_type == REQ_READ || in_w.req_type == REQ_WRITE) begin
          nlen = (in_w.xfer_length > LEN_CAP) ? (LW+1)'(LEN_CAP)
                                                : (LW+1)'(in_w.xfer_length);
          rd_nxt = (in_w.req_type == REQ_READ);
          if (rd_nxt && nlen == '0) nlen = (LW+1)'(1);
          dev_nxt = in_w.dev_addr; off_nxt = in_w.reg_offset;
          wide_nxt = (in_w.dev_addr == cfg.wide_a) || (in_w.dev_addr == cfg.wide_b) ||
                     (in_w.dev_addr == cfg.wide_c);
          left_nxt = 8'(nlen);
          code_nxt = ST_OK; stage_nxt = S_ADDR_W; phase_nxt = P_ST_A;
          tick_nxt = '0; sda_nxt = 1'b0;
        end else if (in_w.req_type == REQ_RECOVER) begin
          code_nxt = ST_OK; phase_nxt = P_REC_HI; tick_nxt = '0;
          scl_nxt = 1'b0; sda_nxt = 1'b0;
        end
      end
      P_ST_A: if (tdone) begin scl_nxt = 1'b0; phase_nxt = P_ST_B; end
      P_ST_B: if (tdone) begin
        if (in_w.scl_in && in_w.sda_in) begin sda_nxt = 1'b1; phase_nxt = P_ST_C; end
        else begin
          if (code_r == ST_OK) code_nxt = ST_BUS_BUSY;
          phase_nxt = P_SP_A; tick_nxt = '0; scl_nxt = 1'b1;
        end
      end
      P_ST_C: if (tdone) begin
        shift_nxt = (stage_r == S_ADDR_R) ? (dev_r | 8'h01) : (dev_r & 8'hFE);
        bit_nxt = 4'd0;
      end
      P_BIT_LOW: if (tdone) begin scl_nxt = 1'b0; phase_nxt = P_BIT_HIGH; end
      P_BIT_HIGH: if (in_w.scl_in && tdone) begin
        scl_nxt = 1'b1;
        if (bit_r < 4'd8) begin
          if (stage_r == S_DATA_R) begin
            shift_nxt = {shift_r[6:0], in_w.sda_in};
            if (bit_r == 4'd7) begin rdv = 1'b1; rdd = shift_nxt; end
          end
          bit_nxt = bit_r + 4'd1;
        end else if (stage_r != S_DATA_R) begin
          if (in_w.sda_in) begin
            if (code_r == ST_OK) begin
              if (stage_r == S_ADDR_W || stage_r == S_ADDR_R) code_nxt = ST_ADDR_NACK;
              else if (stage_r == S_OFF_HI || stage_r == S_OFF_LO) code_nxt = ST_OFF_NACK;
              else code_nxt = ST_DATA_NACK;
            end
            phase_nxt = P_SP_A; tick_nxt = '0;
          end else begin
            bit_nxt = 4'd0;
            case (stage_r)
              S_ADDR_W: begin
                stage_nxt = wide_r ? S_OFF_HI : S_OFF_LO;
                shift_nxt = wide_r ? off_r[15:8] : off_r[7:0];
              end
              S_OFF_HI: begin stage_nxt = S_OFF_LO; shift_nxt = off_r[7:0]; end
              S_OFF_LO: begin
                if (rd_r) begin
                  stage_nxt = S_ADDR_R; phase_nxt = P_ST_A; tick_nxt = '0;
                  sda_nxt = 1'b0;
                end else if (left_r == 8'd0) begin
                  phase_nxt = P_SP_A; tick_nxt = '0;
                end else begin phase_nxt = P_WAIT_DATA; tick_nxt = '0; end
              end
              S_DATA_W: begin
                left_nxt = left_r - 8'd1;
                phase_nxt = (left_nxt == 8'd0) ? P_SP_A : P_WAIT_DATA;
                tick_nxt = '0;
              end
              default: begin stage_nxt = S_DATA_R; shift_nxt = 8'd0; end
            endcase
          end
        end else begin
          left_nxt = left_r - 8'd1;
          if (left_nxt == 8'd0) begin phase_nxt = P_SP_A; tick_nxt = '0; end
          else begin bit_nxt = 4'd0; shift_nxt = 8'd0; end
        end
      end
      P_WAIT_DATA: begin
        scl_nxt = 1'b1;
        if (in_w.wr_data_valid) begin
          shift_nxt = in_w.wr_data; taken = 1'b1; stage_nxt = S_DATA_W; bit_nxt = 4'd0;
        end
      end
      P_SP_A: if (tdone) begin sda_nxt = 1'b1; phase_nxt = P_SP_B; end
      P_SP_B: if (tdone) begin scl_nxt = 1'b0; phase_nxt = P_SP_C; end
      P_SP_C: if (tdone) begin
        if (in_w.scl_in && !in_w.sda_in) begin sda_nxt = 1'b0; phase_nxt = P_SP_D; end
        else begin
          if (code_r == ST_OK) code_nxt = ST_STOP_FAIL;
          phase_nxt = P_IDLE; tick_nxt = '0; scl_nxt = 1'b0; sda_nxt = 1'b0; done = 1'b1;
        end
      end
      P_SP_D: if (tdone) begin
        if (code_r == ST_OK && !(in_w.scl_in && in_w.sda_in)) code_nxt = ST_STOP_FAIL;
        phase_nxt = P_IDLE; tick_nxt = '0; scl_nxt = 1'b0; sda_nxt = 1'b0; done = 1'b1;
      end
      P_REC_HI: if (tdone) begin
        if (in_w.sda_in) begin phase_nxt = P_SP_A; tick_nxt = '0; scl_nxt = 1'b1; end
        else begin scl_nxt = 1'b1; phase_nxt = P_REC_LO; end
      end
      P_REC_LO: if (tdone) begin scl_nxt = 1'b0; phase_nxt = P_REC_HI; end
      default: begin
        phase_nxt = P_IDLE; tick_nxt = '0; scl_nxt = 1'b0; sda_nxt = 1'b0; done = 1'b1;
      end
    endcase
    // Entering a stop or a bit low phase: SCL low; for a bit, SDA from the byte, ACK or NACK slot.
    if (phase_nxt == P_SP_A && phase_r != P_SP_A) scl_nxt = 1'b1;
    if ((phase_r == P_ST_C && tdone) ||
        (phase_r == P_WAIT_DATA && in_w.wr_data_valid) ||
        (phase_r == P_BIT_HIGH && in_w.scl_in && tdone && phase_nxt == P_BIT_HIGH)) begin
      bi = bit_nxt; nb = shift_nxt;
      phase_nxt = P_BIT_LOW; tick_nxt = '0; scl_nxt = 1'b1;
      if (stage_nxt == S_DATA_R) sda_nxt = (bi >= 4'd8) && (left_nxt > 8'd1);
      else if (bi < 4'd8) sda_nxt = !nb[3'(4'd7 - bi)];
      else sda_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE; stage_r <= S_ADDR_W; tick_r <= '0; bit_r <= '0;
      shift_r <= '0; left_r <= '0; wide_r <= 1'b0; dev_r <= '0; off_r <= '0;
      rd_r <= 1'b0; code_r <= ST_OK; scl_r <= 1'b0; sda_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt; stage_r <= stage_nxt; tick_r <= tick_nxt; bit_r <= bit_nxt;
      shift_r <= shift_nxt; left_r <= left_nxt; wide_r <= wide_nxt; dev_r <= dev_nxt;
      off_r <= off_nxt; rd_r <= rd_nxt; code_r <= code_nxt; scl_r <= scl_nxt;
      sda_r <= sda_nxt;
    end
  end

  assign res = '{scl_pull_low: scl_nxt, sda_pull_low: sda_nxt, rd_data: rdd,
                 rd_valid: rdv, wr_data_taken: taken,
                 busy_res: (phase_nxt != P_IDLE), done_res: done, status: code_nxt};

  `I2CM_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(phase_r), "phase not one-hot")
  `I2CM_ASSERT_IMP(a_bitcnt, clk, rst_n, 1'b1, bit_r <= 4'd8, "bit counter overrun")
  `I2CM_ASSERT_NXT(a_done_idle, clk, rst_n, step && done, phase_r == P_IDLE,
                   "done without returning idle")
endmodule

// ===== rtl/i2c_master_register_transfer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_transfer_top
// Tick-driven open-drain I2C master for register read and write transfers and bus recovery.
// ----------------------------------------------------------------------------
//  channel  direction  word
//  in_      sink       one tick: request fields, write byte, SCL/SDA samples
//  out_     source     line drives, received byte, strobes, busy/done/status
//  cfg_     APB slave  half period and three wide-offset device addresses
//
// Each tick word is processed combinationally by the sequencer and its result is
// captured in an output register, so a new tick is taken every cycle unless the output stalls.
// The input is ready whenever the output register is empty or being drained.
// A stall on the output side holds the sequencer state unchanged.
// Reset is synchronous and active low; it clears all control state.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_top #(
  parameter int unsigned MAX_LEN = i2cm_pkg::MAX_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  i2cm_stream_if.sink                 in_ch,
  i2cm_stream_if.source               out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [i2cm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import i2cm_pkg::*;

  cfg_t      cfg;
  out_word_t res;
  out_word_t out_r;
  logic      out_vld_r;
  logic      step;

  i2cm_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  // The sequencer advances exactly on accepted ticks.
  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign step = in_ch.valid && in_ch.ready;

  i2cm_sequencer #(.MAX_LEN(MAX_LEN)) u_seq (
    .clk(clk), .rst_n(rst_n), .step(step), .in_w(in_ch.data), .cfg(cfg), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;
endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// I2C register transfer master testbench
// Drives tick words through the input channel and answers the I2C lines like a
// well-behaved slave: it acknowledges, returns read bits and stretches the
// clock, with faults injected on purpose. Every result word is checked field
// by field against a cycle-true predictor of the sequencer.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  // Line behaviors injected by the bus model.
  typedef enum int {
    F_NONE, F_BUS_BUSY, F_ADDR_NACK, F_OFF_NACK, F_DATA_NACK, F_STOP_FAIL,
    F_STRETCH, F_REC_STUCK, F_RANDOM
  } fault_t;

  // One directed job: the request and the status it must end with.
  typedef struct {
    logic [1:0]  req;
    logic [7:0]  dev;
    logic [15:0] off;
    logic [7:0]  len;
    fault_t      fault;
    logic [2:0]  status;
  } job_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  i2cm_stream_if #(.word_t(in_word_t))  in_if ();
  i2cm_stream_if #(.word_t(out_word_t)) out_if ();

  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]  cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  i2c_master_register_transfer_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if.sink),
    .out_ch      (out_if.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Safety net: the slowest legal run is far below this.
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the configuration and the sequencer as the block holds it.
  // --------------------------------------------------------------------------
  logic [15:0] cur_half = 16'd5;
  logic [7:0]  cur_wa = '0, cur_wb = '0, cur_wc = '0;
  phase_t      seq_phase = P_IDLE;
  stage_t      seq_stage = S_ADDR_W;
  logic [16:0] tick_cnt = '0;
  logic [3:0]  bit_cnt = '0;
  logic [7:0]  shifter = '0, bytes_left = '0, held_dev = '0;
  logic [15:0] held_off = '0;
  logic        wide_off = 1'b0, read_job = 1'b0;
  logic [2:0]  job_code = ST_OK;
  logic        drive_scl = 1'b0, drive_sda = 1'b0, job_done = 1'b0;

  out_word_t   expected_words[$];
  logic [2:0]  expected_status[$];
  int          error_count = 0;
  int          items_sent = 0;
  fault_t      fault = F_NONE;
  bit          no_gaps = 1'b0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  function automatic logic half_elapsed();
    logic [16:0] hp;
    hp = (cur_half == 16'd0) ? 17'd1 : {1'b0, cur_half};
    tick_cnt = tick_cnt + 17'd1;
    if (tick_cnt >= hp) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // SCL low half of a bit; SDA carries the next data bit, the ACK or a release.
  function automatic void start_bit();
    seq_phase = P_BIT_LOW;
    tick_cnt = '0;
    drive_scl = 1'b1;
    if (seq_stage == S_DATA_R)
      drive_sda = (bit_cnt >= 4'd8) && (bytes_left > 8'd1);
    else if (bit_cnt < 4'd8)
      drive_sda = !shifter[3'd7 - bit_cnt[2:0]];
    else
      drive_sda = 1'b0;
  endfunction

  function automatic void go_stop(logic [2:0] c);
    if (job_code == ST_OK) job_code = c;
    seq_phase = P_SP_A;
    tick_cnt = '0;
    drive_scl = 1'b1;
  endfunction

  function automatic void end_job(logic [2:0] c);
    if (job_code == ST_OK) job_code = c;
    seq_phase = P_IDLE;
    tick_cnt = '0;
    drive_scl = 1'b0;
    drive_sda = 1'b0;
    job_done = 1'b1;
  endfunction

  function automatic void next_write_byte();
    if (bytes_left == 8'd0) go_stop(ST_OK);
    else begin
      seq_phase = P_WAIT_DATA;
      tick_cnt = '0;
    end
  endfunction

  // Move on after an acknowledged byte.
  function automatic void after_ack();
    bit_cnt = '0;
    case (seq_stage)
      S_ADDR_W: begin
        seq_stage = wide_off ? S_OFF_HI : S_OFF_LO;
        shifter = wide_off ? held_off[15:8] : held_off[7:0];
        start_bit();
      end
      S_OFF_HI: begin
        seq_stage = S_OFF_LO;
        shifter = held_off[7:0];
        start_bit();
      end
      S_OFF_LO: begin
        if (read_job) begin
          seq_stage = S_ADDR_R;
          seq_phase = P_ST_A;
          tick_cnt = '0;
          drive_sda = 1'b0;
        end else begin
          next_write_byte();
        end
      end
      S_DATA_W: begin
        bytes_left = bytes_left - 8'd1;
        next_write_byte();
      end
      default: begin
        seq_stage = S_DATA_R;
        shifter = '0;
        start_bit();
      end
    endcase
  endfunction

  // One tick of the sequencer; returns the result word it produces.
  function automatic out_word_t predict_tick(in_word_t w);
    out_word_t o;
    logic [7:0] n;
    logic [2:0] c;
    o = '0;
    job_done = 1'b0;
    case (seq_phase)
      P_IDLE: begin
        if (w.req_type == REQ_READ || w.req_type == REQ_WRITE) begin
          n = (w.xfer_length > MAX_LEN_DEF) ? MAX_LEN_DEF[7:0] : w.xfer_length;
          read_job = (w.req_type == REQ_READ);
          if (read_job && n == 8'd0) n = 8'd1;
          held_dev = w.dev_addr;
          held_off = w.reg_offset;
          wide_off = (w.dev_addr == cur_wa) || (w.dev_addr == cur_wb) ||
                     (w.dev_addr == cur_wc);
          bytes_left = n;
          job_code = ST_OK;
          seq_stage = S_ADDR_W;
          seq_phase = P_ST_A;
          tick_cnt = '0;
          drive_sda = 1'b0;
        end else if (w.req_type == REQ_RECOVER) begin
          job_code = ST_OK;
          seq_phase = P_REC_HI;
          tick_cnt = '0;
          drive_scl = 1'b0;
          drive_sda = 1'b0;
        end
      end
      P_ST_A: if (half_elapsed()) begin
        drive_scl = 1'b0;
        seq_phase = P_ST_B;
      end
      P_ST_B: if (half_elapsed()) begin
        if (w.scl_in && w.sda_in) begin
          drive_sda = 1'b1;
          seq_phase = P_ST_C;
        end else go_stop(ST_BUS_BUSY);
      end
      P_ST_C: if (half_elapsed()) begin
        shifter = (seq_stage == S_ADDR_R) ? (held_dev | 8'h01) : (held_dev & 8'hFE);
        bit_cnt = '0;
        start_bit();
      end
      P_BIT_LOW: if (half_elapsed()) begin
        drive_scl = 1'b0;
        seq_phase = P_BIT_HIGH;
      end
      P_BIT_HIGH: if (w.scl_in) begin
        if (half_elapsed()) begin
          drive_scl = 1'b1;
          if (bit_cnt < 4'd8) begin
            if (seq_stage == S_DATA_R) begin
              shifter = {shifter[6:0], w.sda_in};
              if (bit_cnt == 4'd7) begin
                o.rd_valid = 1'b1;
                o.rd_data = shifter;
              end
            end
            bit_cnt = bit_cnt + 4'd1;
            start_bit();
          end else if (seq_stage != S_DATA_R) begin
            if (w.sda_in) begin
              c = ST_DATA_NACK;
              if (seq_stage == S_ADDR_W || seq_stage == S_ADDR_R) c = ST_ADDR_NACK;
              else if (seq_stage == S_OFF_HI || seq_stage == S_OFF_LO) c = ST_OFF_NACK;
              go_stop(c);
            end else after_ack();
          end else begin
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) go_stop(ST_OK);
            else begin
              bit_cnt = '0;
              shifter = '0;
              start_bit();
            end
          end
        end
      end
      P_WAIT_DATA: begin
        drive_scl = 1'b1;
        if (w.wr_data_valid) begin
          shifter = w.wr_data;
          o.wr_data_taken = 1'b1;
          seq_stage = S_DATA_W;
          bit_cnt = '0;
          start_bit();
        end
      end
      P_SP_A: if (half_elapsed()) begin
        drive_sda = 1'b1;
        seq_phase = P_SP_B;
      end
      P_SP_B: if (half_elapsed()) begin
        drive_scl = 1'b0;
        seq_phase = P_SP_C;
      end
      P_SP_C: if (half_elapsed()) begin
        if (w.scl_in && !w.sda_in) begin
          drive_sda = 1'b0;
          seq_phase = P_SP_D;
        end else end_job(ST_STOP_FAIL);
      end
      P_SP_D: if (half_elapsed()) end_job((w.scl_in && w.sda_in) ? ST_OK : ST_STOP_FAIL);
      P_REC_HI: if (half_elapsed()) begin
        if (w.sda_in) go_stop(ST_OK);
        else begin
          drive_scl = 1'b1;
          seq_phase = P_REC_LO;
        end
      end
      P_REC_LO: if (half_elapsed()) begin
        drive_scl = 1'b0;
        seq_phase = P_REC_HI;
      end
      default: end_job(ST_OK);
    endcase
    o.scl_pull_low = drive_scl;
    o.sda_pull_low = drive_sda;
    o.busy_res = (seq_phase != P_IDLE);
    o.done_res = job_done;
    o.status = job_code;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Bus model. The lines follow the master's drives; a slave answers on the
  // ACK and read bits, and the active fault bends the transfer.
  // --------------------------------------------------------------------------
  function automatic void bus_lines(inout in_word_t w);
    logic scl_l, sda_l;
    logic ack_bit;
    scl_l = !drive_scl;
    sda_l = !drive_sda;
    ack_bit = (seq_phase == P_BIT_HIGH) && (bit_cnt == 4'd8) && (seq_stage != S_DATA_R);
    if (seq_phase == P_BIT_HIGH && scl_l) begin
      if ((fault == F_STRETCH && $urandom_range(99) < 40) ||
          (fault == F_RANDOM && $urandom_range(99) < 5))
        scl_l = 1'b0;
    end
    if (ack_bit) begin
      case (fault)
        F_ADDR_NACK: sda_l = (seq_stage == S_ADDR_W);
        F_OFF_NACK:  sda_l = (seq_stage == S_OFF_HI || seq_stage == S_OFF_LO);
        F_DATA_NACK: sda_l = (seq_stage == S_DATA_W);
        F_RANDOM:    sda_l = ($urandom_range(99) < 3);
        default:     sda_l = 1'b0;
      endcase
    end else if (seq_phase == P_BIT_HIGH && seq_stage == S_DATA_R && bit_cnt < 4'd8) begin
      sda_l = 1'($urandom_range(1));
    end else if (seq_phase == P_ST_B && fault == F_BUS_BUSY) begin
      sda_l = 1'b0;
    end else if (seq_phase == P_SP_D && fault == F_STOP_FAIL) begin
      sda_l = 1'b0;
    end else if (seq_phase == P_REC_HI) begin
      sda_l = (fault == F_REC_STUCK) ? ($urandom_range(99) < 40) : 1'b1;
    end
    if (fault == F_RANDOM && $urandom_range(99) < 2) sda_l = !sda_l;
    if (fault == F_RANDOM && $urandom_range(99) < 1) scl_l = !scl_l;
    w.scl_in = scl_l;
    w.sda_in = sda_l;
    w.wr_data = 8'($urandom_range(255));
    w.wr_data_valid = ($urandom_range(99) < 70);
  endfunction

  // Offers one tick word; the line samples are taken on the falling edge at
  // which the word goes out, so they see the predictor after the last tick.
  task automatic send_tick(in_word_t w);
    int gap;
    gap = (!no_gaps && $urandom_range(99) < 30) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bus_lines(w);
    in_if.data <= w;
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    expected_words.push_back(predict_tick(w));
    items_sent++;
  endtask

  // A tick with random request fields: a request is taken only when idle, so
  // idle ticks carry REQ_TICK and busy ticks anything at all.
  function automatic in_word_t filler_word(bit any_req);
    in_word_t w;
    w = '0;
    w.req_type = any_req ? 2'($urandom_range(3)) : REQ_TICK;
    w.dev_addr = 8'($urandom_range(255));
    w.reg_offset = 16'($urandom_range(65535));
    w.xfer_length = 8'($urandom_range(255));
    return w;
  endfunction

  task automatic run_job(logic [1:0] req, logic [7:0] dev, logic [15:0] off,
                         logic [7:0] len);
    in_word_t w;
    w = filler_word(1'b0);
    w.req_type = req;
    w.dev_addr = dev;
    w.reg_offset = off;
    w.xfer_length = len;
    send_tick(w);
    while (seq_phase != P_IDLE) send_tick(filler_word(1'b1));
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_HALF: cur_half = val[15:0];
      REG_WA:   cur_wa = val[7:0];
      REG_WB:   cur_wb = val[7:0];
      default:  cur_wc = val[7:0];
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Registers change only once every result is in and the block sits idle.
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] hp, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    settle();
    cfg_write(REG_HALF, {16'd0, hp});
    cfg_write(REG_WA, {24'd0, a});
    cfg_write(REG_WB, {24'd0, b});
    cfg_write(REG_WC, {24'd0, c});
  endtask

  // --------------------------------------------------------------------------
  // Result side: the receiver stalls at random, holds off once for a long
  // stretch while the sender keeps offering words, and runs one stretch
  // without any stall.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int cyc;
    cyc = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 600 && cyc < 800) out_if.ready <= 1'b0;
      else if (cyc >= 3000 && cyc < 4500) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    out_word_t got, want;
    logic [2:0] st;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_words.size() == 0) begin
        report("unexpected word", 32'(got), 32'd0);
      end else begin
        want = expected_words.pop_front();
        if (got.scl_pull_low !== want.scl_pull_low)
          report("scl_pull_low", 32'(got.scl_pull_low), 32'(want.scl_pull_low));
        if (got.sda_pull_low !== want.sda_pull_low)
          report("sda_pull_low", 32'(got.sda_pull_low), 32'(want.sda_pull_low));
        if (got.rd_data !== want.rd_data)
          report("rd_data", 32'(got.rd_data), 32'(want.rd_data));
        if (got.rd_valid !== want.rd_valid)
          report("rd_valid", 32'(got.rd_valid), 32'(want.rd_valid));
        if (got.wr_data_taken !== want.wr_data_taken)
          report("wr_data_taken", 32'(got.wr_data_taken), 32'(want.wr_data_taken));
        if (got.busy_res !== want.busy_res)
          report("busy_res", 32'(got.busy_res), 32'(want.busy_res));
        if (got.done_res !== want.done_res)
          report("done_res", 32'(got.done_res), 32'(want.done_res));
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
      end
      // Directed jobs also carry the status read straight off the spec.
      if (got.done_res === 1'b1 && expected_status.size() != 0) begin
        st = expected_status.pop_front();
        if (got.status !== st) report("job status", 32'(got.status), 32'(st));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  job_row_t jobs[$];

  initial begin : stimulus
    logic [15:0] halves[4];
    logic [7:0]  wides[4][3];
    int          phase_items;
    int          pick;
    logic [7:0]  dev;
    logic [7:0]  len;

    in_if.valid = 1'b0;
    in_if.data = '0;

    // Directed jobs at half period 1 with every wide address still 0, so only
    // device 0 takes two offset bytes.
    jobs = '{
      '{REQ_WRITE,   8'h50, 16'h1234, 8'd1,   F_NONE,      ST_OK},
      '{REQ_WRITE,   8'h00, 16'hFFFF, 8'd2,   F_NONE,      ST_OK},
      '{REQ_READ,    8'hA1, 16'h0000, 8'd0,   F_NONE,      ST_OK},
      '{REQ_READ,    8'h01, 16'h8001, 8'd3,   F_STRETCH,   ST_OK},
      '{REQ_WRITE,   8'hFF, 16'h00FF, 8'd0,   F_NONE,      ST_OK},
      '{REQ_RECOVER, 8'h00, 16'h0000, 8'd0,   F_REC_STUCK, ST_OK},
      '{REQ_RECOVER, 8'hFF, 16'hFFFF, 8'd255, F_NONE,      ST_OK},
      '{REQ_WRITE,   8'h3C, 16'h0010, 8'd1,   F_BUS_BUSY,  ST_BUS_BUSY},
      '{REQ_READ,    8'h3C, 16'h0010, 8'd2,   F_ADDR_NACK, ST_ADDR_NACK},
      '{REQ_WRITE,   8'h00, 16'hABCD, 8'd2,   F_OFF_NACK,  ST_OFF_NACK},
      '{REQ_WRITE,   8'h42, 16'h0055, 8'd3,   F_DATA_NACK, ST_DATA_NACK},
      '{REQ_WRITE,   8'h42, 16'h0055, 8'd1,   F_STOP_FAIL, ST_STOP_FAIL},
      '{REQ_READ,    8'h42, 16'h0055, 8'd2,   F_STOP_FAIL, ST_STOP_FAIL},
      '{REQ_WRITE,   8'hFE, 16'h7F80, 8'd6,   F_NONE,      ST_OK}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A plain tick after reset leaves the block idle with both lines free.
    send_tick(filler_word(1'b0));

    set_config(16'd1, 8'h00, 8'h00, 8'h00);

    foreach (jobs[i]) begin
      fault = jobs[i].fault;
      expected_status.push_back(jobs[i].status);
      run_job(jobs[i].req, jobs[i].dev, jobs[i].off, jobs[i].len);
    end
    fault = F_NONE;

    // Extreme half periods: the largest one only while idle, a zero one with
    // real traffic in the random part below.
    set_config(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    repeat (20) send_tick(filler_word(1'b0));

    halves = '{16'd1, 16'd0, 16'd2, 16'd3};
    wides = '{'{8'h50, 8'hA0, 8'hFF}, '{8'h00, 8'h3C, 8'h7E},
              '{8'hAA, 8'h55, 8'h01}, '{8'h42, 8'h42, 8'h81}};

    foreach (halves[k]) begin
      set_config(halves[k], wides[k][0], wides[k][1], wides[k][2]);
      no_gaps = (k == 2);
      phase_items = items_sent;
      while (items_sent - phase_items < 120) begin
        // Mostly clean jobs with random content; the rest meet a noisy bus.
        fault = ($urandom_range(99) < 25) ? F_RANDOM : F_NONE;
        pick = $urandom_range(99);
        dev = ($urandom_range(99) < 35) ? wides[k][$urandom_range(2)]
                                         : 8'($urandom_range(255));
        len = ($urandom_range(99) < 90) ? 8'($urandom_range(4))
                                         : 8'($urandom_range(5, 12));
        if (pick < 42) run_job(REQ_READ, dev, 16'($urandom_range(65535)), len);
        else if (pick < 84) run_job(REQ_WRITE, dev, 16'($urandom_range(65535)), len);
        else if (pick < 94) begin
          if ($urandom_range(1)) fault = F_REC_STUCK;
          run_job(REQ_RECOVER, dev, 16'($urandom_range(65535)), len);
        end else begin
          repeat ($urandom_range(1, 4)) send_tick(filler_word(1'b0));
        end
      end
    end
    no_gaps = 1'b0;
    fault = F_NONE;

    settle();
    repeat (10) @(posedge clk);
    if (expected_status.size() != 0)
      report("jobs left unfinished", expected_status.size(), 32'd0);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
